// File: rtl/core/gfm_pkg.sv
// Shared types and constants for the GF(2^255-19) multiply and freeze unit.
package gfm_pkg;
	localparam int LIMBS     = 5;
	localparam int IN_W      = 54;
	localparam int OUT_W     = 52;
	localparam int LIMB_BITS = 51;
	localparam int HALF_W    = 27;
	localparam int PP_W      = 2 * HALF_W;
	localparam int PROD_W    = 2 * IN_W;
	localparam int COL_W     = 116;
	localparam int CARRY_W   = COL_W - LIMB_BITS;
	localparam int FRZ_W     = 57;
	localparam int STAGES    = 7;

	localparam logic OP_MUL    = 1'b0;
	localparam logic OP_FREEZE = 1'b1;

	typedef logic [IN_W-1:0]      limb_t;
	typedef logic [OUT_W-1:0]     olimb_t;
	typedef logic [PP_W-1:0]      pp_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [FRZ_W-1:0]     frz_t;
	typedef logic [STAGES:1]      adv_t;

	typedef struct packed {
		logic  opcode;
		limb_t x_limb0;
		limb_t x_limb1;
		limb_t x_limb2;
		limb_t x_limb3;
		limb_t x_limb4;
		limb_t y_limb0;
		limb_t y_limb1;
		limb_t y_limb2;
		limb_t y_limb3;
		limb_t y_limb4;
	} op_item_t;

	typedef struct packed {
		olimb_t out_limb0;
		olimb_t out_limb1;
		olimb_t out_limb2;
		olimb_t out_limb3;
		olimb_t out_limb4;
	} res_item_t;
endpackage

// File: rtl/core/gfm_prod.sv
// Limb products of x and y, built from 27x27 partial products over two stages.
module gfm_prod import gfm_pkg::*; (
	input  logic  clk,
	input  adv_t  adv,
	input  limb_t x [LIMBS],
	input  limb_t y [LIMBS],
	output prod_t prod_s2 [LIMBS][LIMBS]
);
	pp_t ll_s1 [LIMBS][LIMBS];
	pp_t lh_s1 [LIMBS][LIMBS];
	pp_t hl_s1 [LIMBS][LIMBS];
	pp_t hh_s1 [LIMBS][LIMBS];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < LIMBS; i++) begin
				for (int j = 0; j < LIMBS; j++) begin
					ll_s1[i][j] <= PP_W'(x[i][HALF_W-1:0]) * PP_W'(y[j][HALF_W-1:0]);
					lh_s1[i][j] <= PP_W'(x[i][HALF_W-1:0]) * PP_W'(y[j][IN_W-1:HALF_W]);
					hl_s1[i][j] <= PP_W'(x[i][IN_W-1:HALF_W]) * PP_W'(y[j][HALF_W-1:0]);
					hh_s1[i][j] <= PP_W'(x[i][IN_W-1:HALF_W]) * PP_W'(y[j][IN_W-1:HALF_W]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < LIMBS; i++) begin
				for (int j = 0; j < LIMBS; j++) begin
					prod_s2[i][j] <= (PROD_W'(hh_s1[i][j]) << PP_W)
						+ ((PROD_W'(lh_s1[i][j]) + PROD_W'(hl_s1[i][j])) << HALF_W)
						+ PROD_W'(ll_s1[i][j]);
				end
			end
		end
	end
endmodule

// File: rtl/core/gfm_col.sv
// Column sums of the limb products, with the upper columns folded back by 19.
module gfm_col import gfm_pkg::*; (
	input  logic  clk,
	input  adv_t  adv,
	input  prod_t prod_s2 [LIMBS][LIMBS],
	output col_t  col_s4 [LIMBS]
);
	col_t lo_s3 [LIMBS];
	col_t hi_s3 [LIMBS];
	col_t lo_sum [LIMBS];
	col_t hi_sum [LIMBS];

	always_comb begin
		for (int k = 0; k < LIMBS; k++) begin
			lo_sum[k] = '0;
			hi_sum[k] = '0;
		end
		for (int i = 0; i < LIMBS; i++) begin
			for (int j = 0; j < LIMBS; j++) begin
				if (i + j < LIMBS)
					lo_sum[i+j] = lo_sum[i+j] + COL_W'(prod_s2[i][j]);
				else
					hi_sum[i+j-LIMBS] = hi_sum[i+j-LIMBS] + COL_W'(prod_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			lo_s3 <= lo_sum;
			hi_s3 <= hi_sum;
		end
	end

	// 19 * h is formed as 16h + 2h + h.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int k = 0; k < LIMBS; k++)
				col_s4[k] <= lo_s3[k] + (hi_s3[k] << 4) + (hi_s3[k] << 1) + hi_s3[k];
		end
	end
endmodule

// File: rtl/core/gfm_frz.sv
// Freeze path: three carry rounds, then a conditional subtraction of p.
module gfm_frz import gfm_pkg::*; (
	input  logic   clk,
	input  adv_t   adv,
	input  limb_t  x [LIMBS],
	output olimb_t frz_s4 [LIMBS]
);
	localparam frz_t MASK  = (FRZ_W'(1) << LIMB_BITS) - FRZ_W'(1);
	localparam frz_t RADIX = FRZ_W'(1) << LIMB_BITS;

	typedef frz_t vec_t [LIMBS];

	function automatic vec_t carry_round(vec_t v);
		vec_t r;
		frz_t c;
		r = v;
		for (int i = 0; i < LIMBS - 1; i++) begin
			c = r[i] >> LIMB_BITS;
			r[i] = r[i] & MASK;
			r[i+1] = r[i+1] + c;
		end
		c = r[LIMBS-1] >> LIMB_BITS;
		r[LIMBS-1] = r[LIMBS-1] & MASK;
		r[0] = r[0] + (c << 4) + (c << 1) + c;
		return r;
	endfunction

	vec_t v_in, v_s1, v_s2, v_s3;
	vec_t d;
	logic borrow [LIMBS+1];

	always_comb begin
		for (int i = 0; i < LIMBS; i++)
			v_in[i] = FRZ_W'(x[i]);
	end

	always_ff @(posedge clk) begin
		if (adv[1])
			v_s1 <= carry_round(v_in);
		if (adv[2])
			v_s2 <= carry_round(v_s1);
		if (adv[3])
			v_s3 <= carry_round(v_s2);
	end

	// Limb 0 of p is 2^51 - 19; the others are 2^51 - 1.
	always_comb begin
		borrow[0] = 1'b0;
		for (int i = 0; i < LIMBS; i++) begin
			if (i == 0)
				d[i] = v_s3[i] + FRZ_W'(19);
			else
				d[i] = v_s3[i] + RADIX - MASK - FRZ_W'(borrow[i]);
			borrow[i+1] = ~d[i][LIMB_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < LIMBS; i++)
				frz_s4[i] <= borrow[LIMBS] ? v_s3[i][OUT_W-1:0]
					: OUT_W'(d[i] & MASK);
		end
	end
endmodule

// File: rtl/core/gfm_carry.sv
// Carry chain of the multiply path and the final result register.
module gfm_carry import gfm_pkg::*; (
	input  logic      clk,
	input  adv_t      adv,
	input  logic      op_s6,
	input  col_t      col_s4 [LIMBS],
	input  olimb_t    frz_s4 [LIMBS],
	output res_item_t res_s7
);
	typedef logic [LIMB_BITS-1:0] l51_t;
	localparam int SUM0_W = CARRY_W + 6;

	l51_t   l0_s5, l1_s5, l0_s6, l1_s6, l2_s6, l3_s6;
	col_t   t2_s5, c3_s5, c4_s5, t4_s6;
	olimb_t frz_s5 [LIMBS];
	olimb_t frz_s6 [LIMBS];
	col_t   t1, t2, t3, t4;
	logic [CARRY_W-1:0] c_top;
	logic [SUM0_W-1:0]  sum0;
	res_item_t mul_res;

	assign t1 = col_s4[1] + (col_s4[0] >> LIMB_BITS);
	assign t2 = col_s4[2] + (t1 >> LIMB_BITS);
	assign t3 = c3_s5 + (t2_s5 >> LIMB_BITS);
	assign t4 = c4_s5 + (t3 >> LIMB_BITS);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			l0_s5  <= col_s4[0][LIMB_BITS-1:0];
			l1_s5  <= t1[LIMB_BITS-1:0];
			t2_s5  <= t2;
			c3_s5  <= col_s4[3];
			c4_s5  <= col_s4[4];
			frz_s5 <= frz_s4;
		end
		if (adv[6]) begin
			l0_s6  <= l0_s5;
			l1_s6  <= l1_s5;
			l2_s6  <= t2_s5[LIMB_BITS-1:0];
			l3_s6  <= t3[LIMB_BITS-1:0];
			t4_s6  <= t4;
			frz_s6 <= frz_s5;
		end
	end

	// The top carry wraps to limb 0 times 19, and one more carry goes into limb 1.
	always_comb begin
		c_top = t4_s6[COL_W-1:LIMB_BITS];
		sum0 = SUM0_W'(l0_s6) + (SUM0_W'(c_top) << 4) + (SUM0_W'(c_top) << 1)
			+ SUM0_W'(c_top);
		mul_res.out_limb0 = OUT_W'(sum0[LIMB_BITS-1:0]);
		mul_res.out_limb1 = OUT_W'(l1_s6) + OUT_W'(sum0 >> LIMB_BITS);
		mul_res.out_limb2 = OUT_W'(l2_s6);
		mul_res.out_limb3 = OUT_W'(l3_s6);
		mul_res.out_limb4 = OUT_W'(t4_s6[LIMB_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			unique case (op_s6)
				OP_FREEZE: res_s7 <= '{frz_s6[0], frz_s6[1], frz_s6[2], frz_s6[3],
					frz_s6[4]};
				default:   res_s7 <= mul_res;
			endcase
		end
	end
endmodule

// File: rtl/core/gf25519_mul_and_freeze_unit.sv
// Seven-stage pipeline: products, column sums, fold by 19, carries, and result.
// Multiply or freeze over GF(2^255-19) in radix 2^51. The unit accepts one
// transaction per clock while op_stall is low, and returns the results in
// order. The stage count is set by the multiply path: a stage of
// 27x27-bit partial products, a stage that joins them, column sums, the fold
// by 19 and three stages of carry chain; freeze takes the same path length.
// Every stage holds its valid bit and advances on its own, so a stalled
// result lets earlier stages keep filling empty slots behind it.
module gf25519_mul_and_freeze_unit import gfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_item_t  op,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);
	logic [STAGES:1] vld_q;
	logic [STAGES:1] op_q;
	logic [STAGES:0] vin;
	logic [STAGES:0] opin;
	adv_t adv;
	limb_t x [LIMBS];
	limb_t y [LIMBS];
	prod_t prod_s2 [LIMBS][LIMBS];
	col_t col_s4 [LIMBS];
	olimb_t frz_s4 [LIMBS];

	assign x = '{op.x_limb0, op.x_limb1, op.x_limb2, op.x_limb3, op.x_limb4};
	assign y = '{op.y_limb0, op.y_limb1, op.y_limb2, op.y_limb3, op.y_limb4};

	// A stage takes new data when it is empty or the stage after it moves on.
	always_comb begin
		adv[STAGES] = ~vld_q[STAGES] | ~res_stall;
		for (int k = STAGES - 1; k >= 1; k--)
			adv[k] = ~vld_q[k] | adv[k+1];
		vin  = {vld_q, op_valid};
		opin = {op_q, op.opcode};
	end

	assign op_stall  = ~adv[1];
	assign res_valid = vld_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++)
				if (adv[k])
					vld_q[k] <= vin[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= STAGES; k++)
			if (adv[k])
				op_q[k] <= opin[k-1];
	end

	gfm_prod u_prod (
		.clk     (clk),
		.adv     (adv),
		.x       (x),
		.y       (y),
		.prod_s2 (prod_s2)
	);

	gfm_col u_col (
		.clk     (clk),
		.adv     (adv),
		.prod_s2 (prod_s2),
		.col_s4  (col_s4)
	);

	gfm_frz u_frz (
		.clk    (clk),
		.adv    (adv),
		.x      (x),
		.frz_s4 (frz_s4)
	);

	gfm_carry u_carry (
		.clk    (clk),
		.adv    (adv),
		.op_s6  (op_q[STAGES-1]),
		.col_s4 (col_s4),
		.frz_s4 (frz_s4),
		.res_s7 (res)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> (res_valid && res_stall))
		else $error("input stalled while the output stage could move");

	a_mul_limbs_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && op_q[STAGES] == OP_MUL) |->
		(!res.out_limb0[LIMB_BITS] && !res.out_limb2[LIMB_BITS]
		&& !res.out_limb3[LIMB_BITS] && !res.out_limb4[LIMB_BITS]))
		else $error("multiply result limb not reduced");

	a_frz_limbs_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && op_q[STAGES] == OP_FREEZE) |->
		(!res.out_limb0[LIMB_BITS] && !res.out_limb1[LIMB_BITS]
		&& !res.out_limb2[LIMB_BITS] && !res.out_limb3[LIMB_BITS]
		&& !res.out_limb4[LIMB_BITS]))
		else $error("freeze result limb not reduced");
`endif
endmodule

// File: tb/gfm_checker.sv
// Checker that predicts GF(2^255-19) multiply and freeze results and compares them.
`timescale 1ns / 100ps
module gfm_checker import gfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  logic      op_stall,
	input  op_item_t  op,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_item_t res,
	output int        fail_count,
	output int        pending
);
	localparam logic [50:0] MASK51 = {51{1'b1}};

	res_item_t expected_results[$];

	function automatic res_item_t field_multiply(op_item_t t);
		logic [53:0] x[5];
		logic [53:0] y[5];
		logic [127:0] col[5];
		logic [127:0] a;
		logic [63:0] c;
		logic [63:0] l0;
		res_item_t r;
		x = '{t.x_limb0, t.x_limb1, t.x_limb2, t.x_limb3, t.x_limb4};
		y = '{t.y_limb0, t.y_limb1, t.y_limb2, t.y_limb3, t.y_limb4};
		for (int k = 0; k < 5; k++) col[k] = '0;
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++) begin
				a = 128'(x[i]);
				if (i + j >= 5) begin
					a = a * 19;
					col[i + j - 5] += a * 128'(y[j]);
				end else begin
					col[i + j] += a * 128'(y[j]);
				end
			end
		for (int i = 0; i < 4; i++) begin
			col[i + 1] += 128'(64'(col[i] >> 51));
			col[i] = 128'(col[i][50:0]);
		end
		c = 64'(col[4] >> 51);
		l0 = 64'(col[0][50:0]) + 64'(19) * c;
		r.out_limb0 = 52'(l0[50:0]);
		r.out_limb1 = 52'(64'(col[1][50:0]) + (l0 >> 51));
		r.out_limb2 = 52'(col[2][50:0]);
		r.out_limb3 = 52'(col[3][50:0]);
		r.out_limb4 = 52'(col[4][50:0]);
		return r;
	endfunction

	function automatic res_item_t field_freeze(op_item_t t);
		logic [63:0] v[5];
		logic [63:0] d[5];
		logic [63:0] c;
		logic borrow;
		res_item_t r;
		v = '{64'(t.x_limb0), 64'(t.x_limb1), 64'(t.x_limb2), 64'(t.x_limb3),
			64'(t.x_limb4)};
		for (int rd = 0; rd < 3; rd++) begin
			for (int i = 0; i < 4; i++) begin
				c = v[i] >> 51;
				v[i] &= 64'(MASK51);
				v[i + 1] += c;
			end
			c = v[4] >> 51;
			v[4] &= 64'(MASK51);
			v[0] += 64'(19) * c;
		end
		d[0] = v[0] + 64'd19;
		borrow = ~d[0][51];
		d[0] &= 64'(MASK51);
		for (int i = 1; i < 5; i++) begin
			d[i] = v[i] + 64'd1 - 64'(borrow);
			borrow = ~d[i][51];
			d[i] &= 64'(MASK51);
		end
		// Without a borrow the value was at least p, so the difference is kept.
		if (!borrow) v = d;
		r = {52'(v[0]), 52'(v[1]), 52'(v[2]), 52'(v[3]), 52'(v[4])};
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		res_item_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (op_valid && !op_stall)
				expected_results.push_back(op.opcode == OP_FREEZE ? field_freeze(op)
					: field_multiply(op));
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", res);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (e !== res) begin
						if (fail_count < 10)
							$display("mismatch: expected %h %h %h %h %h got %h %h %h %h %h",
								e.out_limb0, e.out_limb1, e.out_limb2, e.out_limb3,
								e.out_limb4, res.out_limb0, res.out_limb1,
								res.out_limb2, res.out_limb3, res.out_limb4);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: tb/testbench.sv
// Stimulus and verdict for the GF(2^255-19) multiply and freeze unit.
`timescale 1ns / 100ps
module testbench;
	import gfm_pkg::*;

	localparam logic [53:0] LIMB_MAX = {54{1'b1}};
	localparam logic [53:0] P_LOW    = 54'h7ffffffffffed;
	localparam logic [53:0] P_HIGH   = 54'h7ffffffffffff;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      op_valid = 1'b0;
	logic      op_stall;
	op_item_t  op = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res;
	int        fail_count;
	int        pending;
	bit        hold_off = 1'b0;
	bit        sending_done = 1'b0;

	always #6 clk = ~clk;

	gf25519_mul_and_freeze_unit i_dut (.*);

	gfm_checker i_checker (.*);

	function automatic limb_t pick_limb();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return LIMB_MAX;
			2: return limb_t'($urandom_range(0, 40));
			3: return {3'b0, {51{1'b1}}} - limb_t'($urandom_range(0, 20));
			4: return limb_t'({$urandom(), $urandom()}) & {3'b0, {51{1'b1}}};
			default: return limb_t'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	task automatic send_op(op_item_t t);
		op <= t;
		op_valid <= 1'b1;
		do @(posedge clk); while (op_stall);
		@(negedge clk);
	endtask

	task automatic send_idle(int n);
		op_valid <= 1'b0;
		op <= '0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		op_item_t t;
		limb_t dir_x[8][5];
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed: zero, all ones, p, p+1, p-1, one, all limbs 2^51-1, and a top limb of 2^52-1.
		dir_x[0] = '{default: '0};
		dir_x[1] = '{default: LIMB_MAX};
		dir_x[2] = '{P_LOW, P_HIGH, P_HIGH, P_HIGH, P_HIGH};
		dir_x[3] = '{P_LOW + 1, P_HIGH, P_HIGH, P_HIGH, P_HIGH};
		dir_x[4] = '{P_LOW - 1, P_HIGH, P_HIGH, P_HIGH, P_HIGH};
		dir_x[5] = '{54'd1, 54'd0, 54'd0, 54'd0, 54'd0};
		dir_x[6] = '{P_HIGH, P_HIGH, P_HIGH, P_HIGH, P_HIGH};
		dir_x[7] = '{54'd0, 54'd0, 54'd0, 54'd0, {54{1'b1}} >> 2};
		for (int i = 0; i < 8; i++)
			for (int o = 0; o < 2; o++) begin
				t.opcode = (o == 0) ? OP_MUL : OP_FREEZE;
				{t.x_limb0, t.x_limb1, t.x_limb2, t.x_limb3, t.x_limb4} =
					{dir_x[i][0], dir_x[i][1], dir_x[i][2], dir_x[i][3], dir_x[i][4]};
				// Freeze gets random y to show that y is ignored.
				{t.y_limb0, t.y_limb1, t.y_limb2, t.y_limb3, t.y_limb4} = (o == 0) ?
					{dir_x[7 - i][0], dir_x[7 - i][1], dir_x[7 - i][2], dir_x[7 - i][3],
					dir_x[7 - i][4]} : {pick_limb(), pick_limb(), pick_limb(),
					pick_limb(), pick_limb()};
				send_op(t);
			end
		for (int n = 0; n < 1350; n++) begin
			t.opcode = $urandom_range(0, 1) ? OP_FREEZE : OP_MUL;
			t.x_limb0 = pick_limb();
			t.x_limb1 = pick_limb();
			t.x_limb2 = pick_limb();
			t.x_limb3 = pick_limb();
			t.x_limb4 = pick_limb();
			t.y_limb0 = pick_limb();
			t.y_limb1 = pick_limb();
			t.y_limb2 = pick_limb();
			t.y_limb3 = pick_limb();
			t.y_limb4 = pick_limb();
			// Squaring: y equal to x.
			if ($urandom_range(0, 7) == 0)
				{t.y_limb0, t.y_limb1, t.y_limb2, t.y_limb3, t.y_limb4} =
					{t.x_limb0, t.x_limb1, t.x_limb2, t.x_limb3, t.x_limb4};
			if (n == 600) hold_off = 1'b1;
			send_op(t);
			if (!hold_off && $urandom_range(0, 2) == 0) send_idle(pick_gap());
		end
		send_idle(1);
		sending_done = 1'b1;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[gf25519_mul_and_freeze_unit] OK");
		else
			$display("[gf25519_mul_and_freeze_unit] ERROR");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps going.
	initial begin
		int len;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
				res_stall <= 1'b0;
			end else if (!sending_done && $urandom_range(0, 3) == 0) begin
				len = pick_gap() + 1;
				res_stall <= 1'b1;
				repeat (len) @(negedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2000000;
		$display("[gf25519_mul_and_freeze_unit] ERROR");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/gfm_pkg.sv
rtl/core/gfm_prod.sv
rtl/core/gfm_col.sv
rtl/core/gfm_frz.sv
rtl/core/gfm_carry.sv
rtl/core/gf25519_mul_and_freeze_unit.sv
tb/gfm_checker.sv
tb/testbench.sv
